[rtl/scsa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the size-class slab allocator.
// Used by scsa_ctrl, scsa_datapath and size_class_slab_allocator_top.
package scsa_pkg;

    localparam int ADDR_W  = 18;
    localparam int SIZE_W  = 16;
    localparam int CFG_W   = 6;
    localparam int OWNER_W = 3;
    localparam int OP_W    = 4;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PAGE   = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // owner code of a page granted whole
    localparam logic [OWNER_W-1:0] WHOLE_PAGE = 3'd7;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT     = 4'd1;
    localparam logic [OP_W-1:0] OP_DECODE     = 4'd2;
    localparam logic [OP_W-1:0] OP_PAGE_POP   = 4'd3;
    localparam logic [OP_W-1:0] OP_FILL       = 4'd4;
    localparam logic [OP_W-1:0] OP_CHUNK_POP  = 4'd5;
    localparam logic [OP_W-1:0] OP_ADDR       = 4'd6;
    localparam logic [OP_W-1:0] OP_PAGE_PUSH  = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_START  = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd9;
    localparam logic [OP_W-1:0] OP_CHUNK_PUSH = 4'd10;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd11;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] block_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } out_item_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic [1:0]      code;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic big;
        logic bin_err;
        logic bin_empty;
        logic page_none;
        logic range_err;
        logic off_zero;
        logic owner_whole;
        logic owner_bad;
        logic fill_last;
        logic div_last;
        logic chunk_bad;
        logic out_free;
    } dp_stat_t;

endpackage

[rtl/scsa_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the size-class slab allocator.
// Depends on scsa_pkg; drives scsa_datapath through dp_cmd_t.
module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_PGPOP = 4'd2;
    localparam logic [3:0] S_FILL  = 4'd3;
    localparam logic [3:0] S_CHRD  = 4'd4;
    localparam logic [3:0] S_CHPOP = 4'd5;
    localparam logic [3:0] S_ADDR  = 4'd6;
    localparam logic [3:0] S_FOWN  = 4'd7;
    localparam logic [3:0] S_FDIV  = 4'd8;
    localparam logic [3:0] S_FCHK  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        cmd.err    = 1'b0;
        cmd.code   = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.op = OP_DECODE;
                if (stat.is_free)
                begin
                    if (stat.range_err)
                    begin
                        cmd.err    = 1'b1;
                        cmd.code   = ST_BAD_FREE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FOWN;
                    end
                end
                else if (stat.big)
                begin
                    if (stat.page_none)
                    begin
                        cmd.err    = 1'b1;
                        cmd.code   = ST_NO_PAGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PGPOP;
                    end
                end
                else if (stat.bin_err)
                begin
                    cmd.err    = 1'b1;
                    cmd.code   = ST_TOO_LARGE;
                    state_next = S_DONE;
                end
                else if (stat.bin_empty)
                begin
                    if (stat.page_none)
                    begin
                        cmd.err    = 1'b1;
                        cmd.code   = ST_NO_PAGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PGPOP;
                    end
                end
                else
                begin
                    state_next = S_CHRD;
                end
            end
            S_PGPOP:
            begin
                cmd.op     = OP_PAGE_POP;
                state_next = stat.big ? S_DONE : S_FILL;
            end
            S_FILL:
            begin
                cmd.op = OP_FILL;
                if (stat.fill_last)
                begin
                    state_next = S_CHRD;
                end
            end
            S_CHRD:
            begin
                state_next = S_CHPOP;
            end
            S_CHPOP:
            begin
                cmd.op     = OP_CHUNK_POP;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.op     = OP_ADDR;
                state_next = S_DONE;
            end
            S_FOWN:
            begin
                state_next = S_DONE;
                if (stat.off_zero)
                begin
                    if (stat.owner_whole)
                    begin
                        cmd.op = OP_PAGE_PUSH;
                    end
                    else
                    begin
                        cmd.err  = 1'b1;
                        cmd.code = ST_BAD_FREE;
                    end
                end
                else if (stat.owner_bad)
                begin
                    cmd.err  = 1'b1;
                    cmd.code = ST_BAD_FREE;
                end
                else
                begin
                    cmd.op     = OP_DIV_START;
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                state_next = S_DONE;
                if (stat.chunk_bad)
                begin
                    cmd.err  = 1'b1;
                    cmd.code = ST_BAD_FREE;
                end
                else
                begin
                    cmd.op = OP_CHUNK_PUSH;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/scsa_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the size-class slab allocator: lists, link memories, divider, output.
// Depends on scsa_pkg; commanded by scsa_ctrl.
module scsa_datapath
    import scsa_pkg::*;
#(
    parameter int NUM_PAGES    = 64,
    parameter int PAGE_BYTES   = 4096,
    parameter int NUM_BINS     = 7,
    parameter int HEADER_BYTES = 4,
    parameter int MIN_SHIFT    = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int PGB   = $clog2(PAGE_BYTES);
    localparam int PW    = $clog2(NUM_PAGES);
    localparam int PTW   = $clog2(NUM_PAGES + 1);
    localparam int SLOTS = PAGE_BYTES / (HEADER_BYTES + (1 << MIN_SHIFT));
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = PW + SW;
    localparam int LW    = CW + 1;
    localparam int DEPTH = NUM_PAGES * (1 << SW);
    localparam int DCW   = $clog2(PGB);
    localparam int PRW   = SW + PGB + 1;

    localparam logic [PTW-1:0] PAGE_NONE  = PTW'(NUM_PAGES);
    localparam logic [LW-1:0]  CHUNK_NONE = {1'b1, {CW{1'b0}}};

    // per-bin chunk size with header, and chunks per page
    logic [PGB:0] tot_tab [NUM_BINS];
    logic [PGB:0] per_tab [NUM_BINS];

    for (genvar g = 0; g < NUM_BINS; g++)
    begin : g_bin
        localparam int TOT = HEADER_BYTES + (1 << (MIN_SHIFT + g));
        localparam int PER = PAGE_BYTES / TOT;
        assign tot_tab[g] = (PGB + 1)'(TOT);
        assign per_tab[g] = (PGB + 1)'(PER);
    end

    // memories
    logic [PTW-1:0]     page_link_mem  [NUM_PAGES];
    logic [OWNER_W-1:0] page_owner_mem [NUM_PAGES];
    logic [LW-1:0]      chunk_link_mem [DEPTH];

    logic [PTW-1:0]     page_link_rd_reg;
    logic [OWNER_W-1:0] owner_rd_reg;
    logic [LW-1:0]      chunk_rd_reg;

    // control state
    logic [CFG_W-1:0]   ffp_reg;
    logic [PTW-1:0]     page_top_reg;
    logic [LW-1:0]      bin_top_reg [NUM_BINS];
    logic [NUM_PAGES-1:0] link_vld_reg;
    logic               out_valid_reg;

    // payload
    logic               func_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PW-1:0]      page_reg;
    logic [OWNER_W-1:0] bin_reg;
    logic [SW-1:0]      fill_reg;
    logic [PRW-1:0]     prod_reg;
    logic [PGB:0]       rem_reg;
    logic [PGB-1:0]     quo_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [1:0]         res_status_reg;
    out_item_t          out_item_reg;

    // decode
    logic [SIZE_W-1:0]  size_m1;
    logic               bin_found;
    logic [OWNER_W-1:0] bin_calc;
    logic [OWNER_W-1:0] bin_idx;
    logic [ADDR_W-1:0]  in_page_full;
    logic [ADDR_W-1:0]  page_full;
    logic [PGB-1:0]     off;
    logic [PW-1:0]      top_idx;
    logic [PTW-1:0]     link_default;
    logic [PTW-1:0]     link_next;
    logic [LW-1:0]      bin_top_sel;
    logic [PGB:0]       div_tmp;
    logic [LW-1:0]      fill_id;
    logic [LW-1:0]      push_id;

    always_comb
    begin
        size_m1   = size_reg - SIZE_W'(1);
        bin_found = 1'b0;
        bin_calc  = '0;
        if (size_reg == '0)
        begin
            bin_found = 1'b1;
        end
        else
        begin
            for (int g = NUM_BINS - 1; g >= 0; g--)
            begin
                if ((size_m1 >> (MIN_SHIFT + g)) == '0)
                begin
                    bin_found = 1'b1;
                    bin_calc  = OWNER_W'(g);
                end
            end
        end
    end

    assign bin_idx      = (bin_reg < OWNER_W'(NUM_BINS)) ? bin_reg : '0;
    assign bin_top_sel  = bin_top_reg[bin_idx];
    assign in_page_full = in_item.block_address >> PGB;
    assign page_full    = addr_reg >> PGB;
    assign off          = addr_reg[PGB-1:0];
    assign top_idx      = page_top_reg[PW-1:0];
    // a link never written since the last rebuild follows the rebuilt chain
    assign link_default = (ADDR_W'(top_idx) == ADDR_W'(ffp_reg)) ? PAGE_NONE
                        : PTW'(top_idx) - PTW'(1);
    assign link_next    = link_vld_reg[top_idx] ? page_link_rd_reg : link_default;
    assign div_tmp      = {rem_reg[PGB-1:0], quo_reg[PGB-1]};
    assign fill_id      = {1'b0, page_reg, fill_reg};
    assign push_id      = {1'b0, page_reg, quo_reg[SW-1:0]};

    always_comb
    begin
        stat.is_free     = (func_reg == FUNC_FREE);
        stat.big         = {1'b0, size_reg} > (SIZE_W + 1)'(PAGE_BYTES / 2);
        stat.bin_err     = !bin_found || (per_tab[bin_calc] == '0);
        stat.bin_empty   = bin_top_reg[bin_calc][LW-1];
        stat.page_none   = (page_top_reg >= PAGE_NONE);
        stat.range_err   = (page_full >= ADDR_W'(NUM_PAGES))
                        || (page_full < ADDR_W'(ffp_reg));
        stat.off_zero    = (off == '0);
        stat.owner_whole = (owner_rd_reg == WHOLE_PAGE);
        stat.owner_bad   = (owner_rd_reg >= OWNER_W'(NUM_BINS))
                        || (off < PGB'(HEADER_BYTES));
        stat.fill_last   = ((PGB + 1)'(fill_reg) == per_tab[bin_idx] - (PGB + 1)'(1));
        stat.div_last    = (div_cnt_reg == DCW'(PGB - 1));
        stat.chunk_bad   = (rem_reg != '0) || ({1'b0, quo_reg} >= per_tab[bin_idx]);
        stat.out_free    = !out_valid_reg || !out_stall;
    end

    // memories: write one address, read registered
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PAGE_PUSH)
        begin
            page_link_mem[page_reg] <= page_top_reg;
        end
        page_link_rd_reg <= page_link_mem[top_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PAGE_POP)
        begin
            page_owner_mem[top_idx] <= stat.big ? WHOLE_PAGE : bin_reg;
        end
        owner_rd_reg <= page_owner_mem[page_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FILL)
        begin
            chunk_link_mem[fill_id[CW-1:0]] <= bin_top_sel;
        end
        else if (cmd.op == OP_CHUNK_PUSH)
        begin
            chunk_link_mem[push_id[CW-1:0]] <= bin_top_sel;
        end
        chunk_rd_reg <= chunk_link_mem[bin_top_sel[CW-1:0]];
    end

    // list heads and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ffp_reg       <= '0;
            page_top_reg  <= PTW'(NUM_PAGES - 1);
            link_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BINS; b++)
            begin
                bin_top_reg[b] <= CHUNK_NONE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                ffp_reg      <= cfg_data;
                page_top_reg <= (ADDR_W'(cfg_data) < ADDR_W'(NUM_PAGES))
                              ? PTW'(NUM_PAGES - 1) : PAGE_NONE;
                link_vld_reg <= '0;
                for (int b = 0; b < NUM_BINS; b++)
                begin
                    bin_top_reg[b] <= CHUNK_NONE;
                end
            end
            else
            begin
                case (cmd.op)
                    OP_PAGE_POP:
                    begin
                        page_top_reg <= link_next;
                    end
                    OP_PAGE_PUSH:
                    begin
                        page_top_reg           <= PTW'(page_reg);
                        link_vld_reg[page_reg] <= 1'b1;
                    end
                    OP_FILL:
                    begin
                        bin_top_reg[bin_idx] <= fill_id;
                    end
                    OP_CHUNK_POP:
                    begin
                        bin_top_reg[bin_idx] <= chunk_rd_reg;
                    end
                    OP_CHUNK_PUSH:
                    begin
                        bin_top_reg[bin_idx] <= push_id;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == OP_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                func_reg <= in_item.func;
                size_reg <= in_item.req_size;
                addr_reg <= in_item.block_address;
                page_reg <= in_page_full[PW-1:0];
            end
            OP_DECODE:
            begin
                bin_reg <= bin_calc;
            end
            OP_PAGE_POP:
            begin
                page_reg       <= top_idx;
                fill_reg       <= '0;
                res_status_reg <= ST_OK;
                res_addr_reg   <= ADDR_W'(top_idx) << PGB;
            end
            OP_FILL:
            begin
                fill_reg <= fill_reg + SW'(1);
            end
            OP_CHUNK_POP:
            begin
                page_reg <= bin_top_sel[CW-1:SW];
                prod_reg <= PRW'(bin_top_sel[SW-1:0]) * PRW'(tot_tab[bin_idx]);
            end
            OP_ADDR:
            begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= (ADDR_W'(page_reg) << PGB) + ADDR_W'(prod_reg)
                                + ADDR_W'(HEADER_BYTES);
            end
            OP_PAGE_PUSH, OP_CHUNK_PUSH:
            begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= '0;
            end
            OP_DIV_START:
            begin
                bin_reg     <= owner_rd_reg;
                rem_reg     <= '0;
                quo_reg     <= off - PGB'(HEADER_BYTES);
                div_cnt_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                // restoring division, one quotient bit per cycle
                div_cnt_reg <= div_cnt_reg + DCW'(1);
                if (div_tmp >= tot_tab[bin_idx])
                begin
                    rem_reg <= div_tmp - tot_tab[bin_idx];
                    quo_reg <= {quo_reg[PGB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_tmp;
                    quo_reg <= {quo_reg[PGB-2:0], 1'b0};
                end
            end
            OP_LOAD:
            begin
                out_item_reg.granted_address <= res_addr_reg;
                out_item_reg.status          <= res_status_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.err)
        begin
            res_status_reg <= cmd.code;
            res_addr_reg   <= '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[rtl/size_class_slab_allocator_top.sv]
`timescale 1ns / 1ps
// Top level of the size-class slab allocator.
// Depends on scsa_pkg, scsa_ctrl and scsa_datapath.
//
//  channel | signals                  | transaction moves
//  --------+--------------------------+---------------------------------------
//  in      | in_valid, in_stall       | in_item_t: func, req_size, block_address
//  out     | out_valid, out_stall     | out_item_t: granted_address, status
//  cfg     | cfg_we, cfg_data         | first_free_page; rebuilds the page list
//
// One request is in flight at a time; the sequencer steps it through states.
// Alloc from a non-empty bin: accept, decode, chunk read, chunk pop, address, load.
// Bin refill adds a page pop and a fill with one link memory write per chunk
// (up to 113 with default sizes). Whole page: accept, decode, page pop or owner
// check, load. A decode reject goes to load; chunk free runs the bit-serial offset divider.
// Reset is async, active low; it leaves every page on the page list and all
// bins empty, with no clearing pass. The result register frees the input
// side: a new request is taken while a result waits under out_stall, and
// only the final load waits for the output to drain.
module size_class_slab_allocator_top
    import scsa_pkg::*;
#(
    parameter int NUM_PAGES    = 64,
    parameter int PAGE_BYTES   = 4096,
    parameter int NUM_BINS     = 7,
    parameter int HEADER_BYTES = 4,
    parameter int MIN_SHIFT    = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence each request
    scsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // hold lists, link memories and the result register
    scsa_datapath #(
        .NUM_PAGES    (NUM_PAGES),
        .PAGE_BYTES   (PAGE_BYTES),
        .NUM_BINS     (NUM_BINS),
        .HEADER_BYTES (HEADER_BYTES),
        .MIN_SHIFT    (MIN_SHIFT)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for size_class_slab_allocator_top.
// Depends on scsa_pkg and the allocator RTL; holds its own allocator predictor.
module tb;
    import scsa_pkg::*;

    localparam int PAGES     = 64;
    localparam int PAGE_SZ   = 4096;
    localparam int BINS      = 7;
    localparam int HDR       = 4;
    localparam int SHIFT0    = 5;
    localparam int SLOTS     = PAGE_SZ / (HDR + (1 << SHIFT0));
    localparam int CHUNKS    = PAGES * SLOTS;
    localparam int DRAIN_CYC = 200;
    localparam longint CYCLE_LIMIT = 3000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_we;
    logic [CFG_W-1:0] cfg_data;

    // predictor state
    int unsigned base_page;
    int unsigned next_page[PAGES];
    int unsigned free_page_head;
    int unsigned bin_head[BINS];
    int unsigned chunk_next[CHUNKS];
    logic [OWNER_W-1:0] owner_of[PAGES];
    bit          owner_set[PAGES];

    out_item_t   pending_results[$];
    logic [ADDR_W-1:0] live_blocks[$];
    int          errors;
    int          sent;
    int          checked;
    int          n_ok;
    int          n_no_page;
    int          n_too_large;
    int          n_bad_free;
    longint      cycles;

    size_class_slab_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Rebuild the page list from the base page and empty every bin.
    function automatic void rebuild_pool();
        free_page_head = PAGES;
        for (int p = base_page; p < PAGES; p++)
        begin
            next_page[p] = free_page_head;
            free_page_head = p;
        end
        for (int b = 0; b < BINS; b++)
            bin_head[b] = CHUNKS;
        live_blocks.delete();
    endfunction

    function automatic int unsigned take_page();
        int unsigned p;
        p = free_page_head;
        if (p >= PAGES)
            return PAGES;
        free_page_head = next_page[p];
        return p;
    endfunction

    // Work out the allocator's answer to one request and update the state.
    function automatic out_item_t predict_allocator(in_item_t req);
        out_item_t res;
        int unsigned p, b, s, total, per, id, off, slot, owner;
        res.granted_address = '0;
        res.status = ST_OK;
        if (req.func == FUNC_ALLOC)
        begin
            if (req.req_size > PAGE_SZ / 2)
            begin
                p = take_page();
                if (p == PAGES)
                    res.status = ST_NO_PAGE;
                else
                begin
                    owner_of[p] = WHOLE_PAGE;
                    owner_set[p] = 1'b1;
                    res.granted_address = ADDR_W'(p * PAGE_SZ);
                end
            end
            else
            begin
                b = 0;
                if (req.req_size != 0)
                begin
                    s = req.req_size - 1;
                    while (b < 24 && (s >> (SHIFT0 + b)) != 0)
                        b++;
                end
                total = HDR + (1 << (SHIFT0 + b));
                per = (b < BINS) ? PAGE_SZ / total : 0;
                if (b >= BINS || per == 0)
                    res.status = ST_TOO_LARGE;
                else
                begin
                    if (bin_head[b] >= CHUNKS)
                    begin
                        p = take_page();
                        if (p == PAGES)
                            res.status = ST_NO_PAGE;
                        else
                        begin
                            owner_of[p] = OWNER_W'(b);
                            owner_set[p] = 1'b1;
                            for (int i = 0; i < per && i < SLOTS; i++)
                            begin
                                id = p * SLOTS + i;
                                chunk_next[id] = bin_head[b];
                                bin_head[b] = id;
                            end
                        end
                    end
                    if (res.status == ST_OK)
                    begin
                        id = bin_head[b];
                        bin_head[b] = chunk_next[id];
                        res.granted_address = ADDR_W'((id / SLOTS) * PAGE_SZ
                            + (id % SLOTS) * total + HDR);
                    end
                end
            end
        end
        else
        begin
            p = req.block_address / PAGE_SZ;
            off = req.block_address % PAGE_SZ;
            if (p >= PAGES || p < base_page)
                res.status = ST_BAD_FREE;
            else
            begin
                owner = owner_of[p];
                if (off == 0)
                begin
                    if (owner != WHOLE_PAGE)
                        res.status = ST_BAD_FREE;
                    else
                    begin
                        next_page[p] = free_page_head;
                        free_page_head = p;
                    end
                end
                else if (owner >= BINS || off < HDR)
                    res.status = ST_BAD_FREE;
                else
                begin
                    total = HDR + (1 << (SHIFT0 + owner));
                    off -= HDR;
                    slot = off / total;
                    if (off % total != 0 || slot >= PAGE_SZ / total || slot >= SLOTS)
                        res.status = ST_BAD_FREE;
                    else
                    begin
                        id = p * SLOTS + slot;
                        chunk_next[id] = bin_head[owner];
                        bin_head[owner] = id;
                    end
                end
            end
        end
        if (res.status != ST_OK)
            res.granted_address = '0;
        return res;
    endfunction

    // Result side: draw a stall length per transaction, compare on acceptance.
    initial
    begin : result_checker
        int gap;
        out_item_t want;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            @(negedge clk);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            checked++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result addr=%h status=%0d", $time,
                         out_item.granted_address, out_item.status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.granted_address !== want.granted_address)
                begin
                    $display("%0t: granted_address expected %h actual %h", $time,
                             want.granted_address, out_item.granted_address);
                    errors++;
                end
                if (out_item.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, out_item.status);
                    errors++;
                end
            end
        end
    end

    // Send one request; predict at acceptance and track granted blocks.
    task automatic send_request(logic func, logic [SIZE_W-1:0] size,
                                logic [ADDR_W-1:0] addr, bit allow_gap);
        int gap;
        in_item_t req;
        out_item_t res;
        gap = (allow_gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.func = func;
        req.req_size = size;
        req.block_address = addr;
        in_item <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        res = predict_allocator(req);
        pending_results.push_back(res);
        sent++;
        case (res.status)
            ST_OK:        n_ok++;
            ST_NO_PAGE:   n_no_page++;
            ST_TOO_LARGE: n_too_large++;
            default:      n_bad_free++;
        endcase
        if (func == FUNC_ALLOC && res.status == ST_OK)
            live_blocks.push_back(res.granted_address);
        @(negedge clk);
    endtask

    // Drop valid and hold until all results are in, plus the latency margin.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    // Write the base page while idle; the pool is rebuilt.
    task automatic write_base_page(int unsigned page);
        wait_idle();
        cfg_data <= CFG_W'(page);
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        base_page = page;
        rebuild_pool();
    endtask

    // Free address that, within 50 tries, avoids an unwritten owner entry; else the top address.
    function automatic logic [ADDR_W-1:0] safe_noise_address();
        logic [ADDR_W-1:0] a;
        int unsigned p;
        for (int tries = 0; tries < 50; tries++)
        begin
            a = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
            p = a / PAGE_SZ;
            if (p >= PAGES || p < base_page || owner_set[p])
                return a;
        end
        return '1;
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:       return SIZE_W'($urandom_range(0, 65535));
            1:       return SIZE_W'($urandom_range(2049, 4096));
            2:       return SIZE_W'($urandom_range(0, 1));
            default: return SIZE_W'(1 + $urandom_range(0, (32 << $urandom_range(0, 6)) - 1));
        endcase
    endfunction

    // Extremes of the size field, bin edges, and oversized requests.
    task automatic test_directed_alloc();
        send_request(FUNC_ALLOC, 16'd0, '0, 0);
        send_request(FUNC_ALLOC, 16'd1, '1, 0);
        send_request(FUNC_ALLOC, 16'd32, '0, 1);
        send_request(FUNC_ALLOC, 16'd33, '0, 1);
        send_request(FUNC_ALLOC, 16'd512, '0, 0);
        send_request(FUNC_ALLOC, 16'd2048, '0, 1);
        send_request(FUNC_ALLOC, 16'd2049, '0, 0);
        send_request(FUNC_ALLOC, 16'd4096, '0, 1);
        send_request(FUNC_ALLOC, 16'hFFFF, '0, 0);
    endtask

    // Whole-page free, chunk free, misaligned, header, page-start and double frees.
    // Page 63 holds bin 0 chunks and page 57 was granted whole above.
    task automatic test_directed_free();
        send_request(FUNC_FREE, 16'hFFFF, 18'(57 * PAGE_SZ), 0);      // whole page
        send_request(FUNC_FREE, '0, 18'(57 * PAGE_SZ + 8), 1);        // inside whole page
        send_request(FUNC_FREE, '0, 18'(63 * PAGE_SZ + 4), 0);        // chunk of page 63
        send_request(FUNC_FREE, '0, 18'(63 * PAGE_SZ + 4), 0);        // double free
        send_request(FUNC_FREE, '0, 18'(63 * PAGE_SZ), 1);            // start of chunk page
        send_request(FUNC_FREE, '0, 18'(63 * PAGE_SZ + 2), 0);        // inside header
        send_request(FUNC_FREE, '0, 18'(63 * PAGE_SZ + 5), 0);        // misaligned
        send_request(FUNC_FREE, '0, 18'h3FFFF, 1);                    // top of pool
        send_request(FUNC_FREE, '0, 18'(63 * PAGE_SZ + 4 + 36 * 113), 0); // past last slot
        send_request(FUNC_ALLOC, 16'd20, '0, 0);
        send_request(FUNC_ALLOC, 16'd20, '0, 0);
    endtask

    // Drain the pool with whole pages until it runs out.
    task automatic test_exhaustion();
        write_base_page(62);
        for (int i = 0; i < 4; i++)
            send_request(FUNC_ALLOC, 16'd3000, '0, 1);
        send_request(FUNC_ALLOC, 16'd8, '0, 0);
        send_request(FUNC_FREE, '0, 18'(62 * PAGE_SZ), 0);
        send_request(FUNC_FREE, '0, 18'(10 * PAGE_SZ), 0);       // below base page
        send_request(FUNC_ALLOC, 16'd8, '0, 1);
        write_base_page(63);
        send_request(FUNC_ALLOC, 16'd3000, '0, 0);
        send_request(FUNC_ALLOC, 16'd3000, '0, 0);
    endtask

    // Random mix: mostly allocs and frees of live blocks, some noise.
    task automatic test_random(int count);
        int k, idx;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 50)
                send_request(FUNC_ALLOC, random_size(),
                             ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1)), 1);
            else if (k < 90 && live_blocks.size() > 0)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                send_request(FUNC_FREE, SIZE_W'($urandom_range(0, 65535)),
                             live_blocks[idx], 1);
                live_blocks.delete(idx);
            end
            else
                send_request(FUNC_FREE, SIZE_W'($urandom_range(0, 65535)),
                             safe_noise_address(), 1);
            if (i == count / 2)
                wait_idle();
        end
    endtask

    initial
    begin
        errors = 0;
        sent = 0;
        checked = 0;
        cycles = 0;
        n_ok = 0;
        n_no_page = 0;
        n_too_large = 0;
        n_bad_free = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        base_page = 0;
        for (int p = 0; p < PAGES; p++)
            owner_set[p] = 1'b0;
        rebuild_pool();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_alloc();
        test_directed_free();
        test_exhaustion();
        write_base_page(0);
        test_random(500);
        write_base_page(40);
        test_random(300);
        write_base_page(0);
        test_random(320);

        wait_idle();
        $display("Sent %0d requests, checked %0d results over four base-page settings.",
                 sent, checked);
        $display("Outcomes: ok %0d, out of pages %0d, too large %0d, bad free %0d.",
                 n_ok, n_no_page, n_too_large, n_bad_free);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[filelist.f]
rtl/scsa_pkg.sv
rtl/scsa_ctrl.sv
rtl/scsa_datapath.sv
rtl/size_class_slab_allocator_top.sv
verif/tb.sv
